### design/pba_pkg.sv
package pba_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_PEEK  = 3'd3,
    OP_SKIP  = 3'd4,
    OP_CLEAR = 3'd5,
    OP_RESET = 3'd6,
    OP_NOP   = 3'd7
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic take;         // input item accepted this cycle
    logic push_status;  // queue the single status result of that item
    logic push_byte;    // queue the next byte of a read or peek
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_go;    // current input is a read or peek that returns bytes
    logic rd_last;  // byte being emitted is the final one
  } stat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_result;
    logic        accepted;
    logic [12:0] bytes_available;
    logic [12:0] space_free;
    logic [31:0] drop_total;
  } result_t;

endpackage

### design/packet_admission_byte_ring_buffer.sv
// Packet-admission byte ring buffer.
// Input channel (in_valid/in_ready) carries one command per item: begin packet,
// write byte, read, peek, skip, clear drops, reset, or no-op. Output channel
// (out_valid/out_ready) carries results; each command gives one status result,
// except read/peek, which give one result per returned byte (up to MAX_READ),
// last_result marking the final one.
// A two-entry output queue decouples the sides: a new item is taken while one
// result still waits. Non-read items: one per cycle, result visible the cycle
// after acceptance. Read/peek of n bytes: first byte two cycles after
// acceptance, then one byte per cycle, limited by the single registered read
// port of the byte store; the next item is taken after the last byte is queued.
// When out_ready is low the queue fills and in_ready drops; nothing is lost.
// rst (synchronous) clears pointers, counts, the drop total and any pending
// packet; the byte store itself is not cleared and needs no clearing pass.
// Packet bytes become readable only once the last byte of the packet arrives.
module packet_admission_byte_ring_buffer #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_READ     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [15:0] byte_count,
  input  logic [6:0]  request_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_result,
  output logic        accepted,
  output logic [12:0] bytes_available,
  output logic [12:0] space_free,
  output logic [31:0] drop_total
);
  import pba_pkg::*;

  cmd_t    cmd;
  stat_t   st;
  logic    q_space;
  logic    res_push;
  result_t res;
  result_t dout;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_space  (q_space),
    .st       (st),
    .cmd      (cmd)
  );

  pba_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_READ     (MAX_READ)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .byte_count     (byte_count),
    .request_length (request_length),
    .res_push       (res_push),
    .res            (res)
  );

  pba_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .din       (res),
    .q_space   (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign out_byte        = dout.out_byte;
  assign byte_valid      = dout.byte_valid;
  assign last_result     = dout.last_result;
  assign accepted        = dout.accepted;
  assign bytes_available = dout.bytes_available;
  assign space_free      = dout.space_free;
  assign drop_total      = dout.drop_total;

endmodule

### design/pba_ctrl.sv
module pba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           q_space,
  input  pba_pkg::stat_t st,
  output pba_pkg::cmd_t  cmd
);
  import pba_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;

  assign in_ready        = (state == S_IDLE) && q_space;
  assign cmd.take        = in_valid && in_ready;
  assign cmd.push_status = cmd.take && !st.rd_go;
  assign cmd.push_byte   = (state == S_EMIT) && q_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.take && st.rd_go) state <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.push_byte && st.rd_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/pba_dp.sv
module pba_dp #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_READ     = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  pba_pkg::cmd_t    cmd,
  output pba_pkg::stat_t   st,
  input  logic [2:0]       opcode,
  input  logic [7:0]       data_byte,
  input  logic [15:0]      byte_count,
  input  logic [6:0]       request_length,
  output logic             res_push,
  output pba_pkg::result_t res
);
  import pba_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int XW = (CW > 16) ? CW : 16;
  localparam int AW = XW + 1;
  localparam logic [6:0] MR = 7'(MAX_READ);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] mem_q;

  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [CW-1:0] committed, committed_next;
  logic [31:0]   dropped, dropped_next;
  logic [15:0]   pend_rem, pend_rem_next;
  logic [15:0]   pend_total, pend_total_next;
  logic          pend_acc, pend_acc_next;
  logic [PW-1:0] wr_addr, wr_addr_next;
  logic [PW-1:0] rd_addr, rd_addr_next;
  logic [6:0]    rd_left, rd_left_next;

  op_t           op;
  logic [CW-1:0] free_sp;
  logic [6:0]    req_c;
  logic [XW-1:0] rd_min;
  logic [6:0]    rd_n;
  logic [XW-1:0] sk_n;
  logic [AW-1:0] commit_sum;
  logic          we;
  logic          acc;
  result_t       status_res;
  result_t       byte_res;

  function automatic logic [PW-1:0] add_wrap(input logic [PW-1:0] ptr,
                                             input logic [XW-1:0] inc);
    logic [AW-1:0] s;
    s = AW'(ptr) + AW'(inc);
    if (s >= AW'(BUFFER_BYTES)) s = s - AW'(BUFFER_BYTES);
    return PW'(s);
  endfunction

  assign op         = op_t'(opcode);
  assign free_sp    = CW'(BUFFER_BYTES) - committed;
  assign req_c      = (request_length > MR) ? MR : request_length;
  assign rd_min     = (XW'(req_c) > XW'(committed)) ? XW'(committed) : XW'(req_c);
  assign rd_n       = 7'(rd_min);
  assign sk_n       = (XW'(byte_count) > XW'(committed)) ? XW'(committed)
                                                         : XW'(byte_count);
  assign commit_sum = AW'(committed) + AW'(pend_total);

  assign st.rd_go   = ((op == OP_READ) || (op == OP_PEEK)) && (rd_n != 7'd0);
  assign st.rd_last = (rd_left == 7'd1);

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    committed_next     = committed;
    dropped_next       = dropped;
    pend_rem_next      = pend_rem;
    pend_total_next    = pend_total;
    pend_acc_next      = pend_acc;
    wr_addr_next       = wr_addr;
    rd_addr_next       = rd_addr;
    rd_left_next       = rd_left;
    we                 = 1'b0;
    acc                = 1'b0;

    if (cmd.push_byte) begin
      rd_addr_next = add_wrap(rd_addr, XW'(1));
      rd_left_next = rd_left - 7'd1;
    end

    if (cmd.take) begin
      unique case (op) inside
        OP_BEGIN: begin
          pend_total_next = byte_count;
          pend_rem_next   = byte_count;
          wr_addr_next    = write_pointer;
          if (XW'(byte_count) > XW'(free_sp)) begin
            dropped_next  = dropped + 32'd1;
            pend_acc_next = 1'b0;
          end else begin
            acc           = 1'b1;
            pend_acc_next = (byte_count != 16'd0);
          end
        end
        OP_WRITE: begin
          if (pend_rem != 16'd0) begin
            pend_rem_next = pend_rem - 16'd1;
            if (pend_acc) begin
              we           = 1'b1;
              acc          = 1'b1;
              wr_addr_next = add_wrap(wr_addr, XW'(1));
              // last byte of an admitted packet: commit all of it
              if (pend_rem == 16'd1) begin
                write_pointer_next = add_wrap(wr_addr, XW'(1));
                committed_next     = CW'(commit_sum);
                pend_acc_next      = 1'b0;
              end
            end
          end
        end
        OP_READ, OP_PEEK: begin
          if (rd_n != 7'd0) begin
            rd_addr_next = read_pointer;
            rd_left_next = rd_n;
            if (op == OP_READ) begin
              read_pointer_next = add_wrap(read_pointer, XW'(rd_n));
              committed_next    = committed - CW'(rd_n);
            end
          end
        end
        OP_SKIP: begin
          read_pointer_next = add_wrap(read_pointer, sk_n);
          committed_next    = committed - CW'(sk_n);
        end
        OP_CLEAR: begin
          dropped_next = 32'd0;
        end
        OP_RESET: begin
          write_pointer_next = '0;
          read_pointer_next  = '0;
          committed_next     = '0;
          dropped_next       = 32'd0;
          pend_rem_next      = 16'd0;
          pend_total_next    = 16'd0;
          pend_acc_next      = 1'b0;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      committed     <= '0;
      dropped       <= 32'd0;
      pend_rem      <= 16'd0;
      pend_total    <= 16'd0;
      pend_acc      <= 1'b0;
      rd_left       <= 7'd0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      committed     <= committed_next;
      dropped       <= dropped_next;
      pend_rem      <= pend_rem_next;
      pend_total    <= pend_total_next;
      pend_acc      <= pend_acc_next;
      rd_left       <= rd_left_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
    rd_addr <= rd_addr_next;
  end

  // mem_q always holds the byte at rd_addr
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= data_byte;
    mem_q <= mem[rd_addr_next];
  end

  always_comb begin
    status_res.out_byte        = 8'd0;
    status_res.byte_valid      = 1'b0;
    status_res.last_result     = 1'b1;
    status_res.accepted        = acc;
    status_res.bytes_available = 13'(committed_next);
    status_res.space_free      = 13'(CW'(BUFFER_BYTES) - committed_next);
    status_res.drop_total      = dropped_next;

    byte_res.out_byte        = mem_q;
    byte_res.byte_valid      = 1'b1;
    byte_res.last_result     = (rd_left == 7'd1);
    byte_res.accepted        = 1'b0;
    byte_res.bytes_available = 13'(committed);
    byte_res.space_free      = 13'(free_sp);
    byte_res.drop_total      = dropped;
  end

  assign res_push = cmd.push_status || cmd.push_byte;
  assign res      = cmd.push_byte ? byte_res : status_res;

`ifndef SYNTH
  a_commit_bound: assert property (@(posedge clk) disable iff (rst)
    committed <= CW'(BUFFER_BYTES))
    else $error("committed count above buffer size");

  a_pend_nonzero: assert property (@(posedge clk) disable iff (rst)
    pend_acc |-> (pend_rem != 16'd0))
    else $error("admitted packet pending with no bytes left");

  a_emit_left: assert property (@(posedge clk) disable iff (rst)
    cmd.push_byte |-> (rd_left != 7'd0))
    else $error("byte emitted with no bytes left");

  a_read_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && st.rd_go) |=> (rd_left != 7'd0) && !cmd.take)
    else $error("read start did not load byte count");
`endif

endmodule

### design/pba_outq.sv
module pba_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pba_pkg::result_t din,
  output logic             q_space,
  output logic             out_valid,
  input  logic             out_ready,
  output pba_pkg::result_t dout
);
  import pba_pkg::*;

  result_t    slot [2];
  logic       head;
  logic [1:0] count;
  logic       pop;
  logic       tail;

  assign q_space   = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign tail      = head ^ count[0];
  assign dout      = slot[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) head <= ~head;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[tail] <= din;
  end

endmodule
